// ----- sv/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and constants for the rational arithmetic unit: operation
// codes, result field widths and the controller/datapath command and status
// ----------------------------------------------------------------------------
package rau_pkg;

   // result field widths
   localparam int RES_NUM_W  = 32;
   localparam int RES_DEN_W  = 31;
   localparam int RSP_DATA_W = 64;

   // operation codes carried in req_tuser
   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // controller to datapath
   typedef struct packed {
      logic in_ready;   // idle, input transaction may be taken
      logic load;       // capture operands
      logic mul;        // form the three cross products
      logic sum;        // form signed numerator and denominator
      logic abs;        // split into sign and magnitudes
      logic gcd;        // one binary gcd step
      logic div_init;   // latch odd gcd, start quotient
      logic div_step;   // one quotient bit for both divisions
      logic out_load;   // hand result to output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic d_zero;     // unreduced denominator is zero
      logic gcd_done;   // one gcd operand has reached zero
      logic div_last;   // final quotient bit in progress
   } status_type;

endpackage

// ----- sv/rational_arith_unit.sv -----
// ----------------------------------------------------------------------------
// rational_arith_unit
// exact add, subtract, multiply and divide of two fractions, reduced to
// lowest terms with the sign on the numerator
// ----------------------------------------------------------------------------
// sequence from input transaction to rsp_tvalid: operand load, multiply, sum, magnitude,
//   the binary gcd loop, the division loop, then the output register; a zero denominator
//   skips the gcd and division loops. One transaction in flight; the next is taken the
//   cycle after the result moves to the output register
// the gcd loop and the one-bit-per-cycle division set how long a transaction takes
// reset: synchronous, clears the sequencer and the output valid, no input taken
module rational_arith_unit #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                                           clock,
   input  logic                                           reset,
   // input transaction
   input  logic                                           req_tvalid,
   output logic                                           req_tready,
   // a_num, a_den, b_num, b_den from bit 0 up, zero padded
   input  logic [((4*OPERAND_WIDTH-2+7)/8)*8-1:0]         req_tdata,
   // req_type
   input  logic [1:0]                                     req_tuser,
   // result transaction
   output logic                                           rsp_tvalid,
   input  logic                                           rsp_tready,
   // res_num, res_den from bit 0 up, zero padded
   output logic [rau_pkg::RSP_DATA_W-1:0]                 rsp_tdata,
   // div_zero
   output logic                                           rsp_tuser
);

   localparam int W = OPERAND_WIDTH;

   rau_pkg::cmd_type                    cmd;
   rau_pkg::status_type                 st;
   logic signed [W-1:0]                 a_num, b_num;
   logic        [W-2:0]                 a_den, b_den;
   logic        [rau_pkg::RES_NUM_W-1:0] res_num;
   logic        [rau_pkg::RES_DEN_W-1:0] res_den;
   logic                                div_zero;
   logic                                out_free;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic        [rau_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                                rsp_user_ff, rsp_user_in;

   // unpack input fields
   assign a_num = $signed(req_tdata[W-1:0]);
   assign a_den = req_tdata[2*W-2:W];
   assign b_num = $signed(req_tdata[3*W-2:2*W-1]);
   assign b_den = req_tdata[4*W-3:3*W-1];

   // no input transaction is taken while in reset
   assign req_tready = cmd.in_ready && !reset;

   rau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .out_free   (out_free),
      .st         (st),
      .cmd        (cmd)
   );

   rau_dp #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .req_type (rau_pkg::op_type'(req_tuser)),
      .a_num    (a_num),
      .a_den    (a_den),
      .b_num    (b_num),
      .b_den    (b_den),
      .st       (st),
      .res_num  (res_num),
      .res_den  (res_den),
      .div_zero (div_zero)
   );

   // output register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, res_den, res_num};
         rsp_user_in  = div_zero;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- sv/rau_ctrl.sv -----
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer for one transaction: multiply, sum, magnitude, gcd loop,
// shared-divisor division loop, then hand-off to the output register
// ----------------------------------------------------------------------------
module rau_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                out_free,
   input  rau_pkg::status_type st,
   output rau_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_SUM,
      S_ABS,
      S_GCD,
      S_DIV,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.in_ready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_ABS;
         end
         S_ABS: begin
            cmd.abs  = 1'b1;
            state_in = st.d_zero ? S_DONE : S_GCD;
         end
         S_GCD: begin
            if (st.gcd_done) begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end else begin
               cmd.gcd = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // at most one datapath phase per cycle
   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.mul, cmd.sum, cmd.abs, cmd.gcd, cmd.div_step, cmd.out_load}))
      else $error("rau_ctrl: more than one datapath phase active");

   // an accepted transaction goes straight into the multiply phase
   a_load_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.mul)
      else $error("rau_ctrl: multiply phase did not follow operand load");

   // zero denominator skips gcd and division
   a_dzero_skip: assert property (@(posedge clock) disable iff (reset)
      (cmd.abs && st.d_zero) |=> (state_ff == S_DONE))
      else $error("rau_ctrl: zero denominator did not go to result");

   // division starts right after gcd completes
   a_div_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.div_init |=> cmd.div_step)
      else $error("rau_ctrl: division did not follow gcd");

endmodule

// ----- sv/rau_dp.sv -----
// ----------------------------------------------------------------------------
// rau_dp
// datapath: cross products, signed sum, magnitudes, binary gcd and two
// restoring dividers sharing the gcd as divisor
// ----------------------------------------------------------------------------
module rau_dp #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                                 clock,
   input  rau_pkg::cmd_type                     cmd,
   input  rau_pkg::op_type                      req_type,
   input  logic signed [OPERAND_WIDTH-1:0]      a_num,
   input  logic        [OPERAND_WIDTH-2:0]      a_den,
   input  logic signed [OPERAND_WIDTH-1:0]      b_num,
   input  logic        [OPERAND_WIDTH-2:0]      b_den,
   output rau_pkg::status_type                  st,
   output logic        [rau_pkg::RES_NUM_W-1:0] res_num,
   output logic        [rau_pkg::RES_DEN_W-1:0] res_den,
   output logic                                 div_zero
);

   localparam int W  = OPERAND_WIDTH;
   localparam int PW = 2 * OPERAND_WIDTH;
   localparam int CW = $clog2(PW);
   localparam int EW = (PW + 1 > rau_pkg::RES_NUM_W) ? PW + 1 : rau_pkg::RES_NUM_W;

   // operand registers
   rau_pkg::op_type         op_ff, op_in;
   logic signed [W-1:0]     an_ff, an_in;
   logic        [W-2:0]     ad_ff, ad_in;
   logic signed [W-1:0]     bn_ff, bn_in;
   logic        [W-2:0]     bd_ff, bd_in;

   // products, sum, magnitudes
   logic signed [PW-1:0]    m0_ff, m0_in;
   logic signed [PW-1:0]    m1_ff, m1_in;
   logic signed [PW-1:0]    m2_ff, m2_in;
   logic signed [PW-1:0]    n_ff, n_in;
   logic signed [PW-1:0]    d_ff, d_in;
   logic        [PW-1:0]    nm_ff, nm_in;
   logic        [PW-1:0]    dm_ff, dm_in;
   logic                    neg_ff, neg_in;
   logic                    dz_ff, dz_in;

   // gcd and division
   logic        [PW-1:0]    x_ff, x_in;
   logic        [PW-1:0]    y_ff, y_in;
   logic        [PW-1:0]    g_ff, g_in;
   logic        [PW-1:0]    qn_ff, qn_in;
   logic        [PW-1:0]    qd_ff, qd_in;
   logic        [PW-1:0]    rn_ff, rn_in;
   logic        [PW-1:0]    rd_ff, rd_in;
   logic        [CW-1:0]    cnt_ff, cnt_in;

   // combinational helpers
   logic signed [W-1:0]     ad_s, bd_s, mb0_s;
   logic        [PW-1:0]    n_u, d_u;
   logic        [PW-1:0]    xy_diff, yx_diff;
   logic        [PW:0]      g_ext, tn, td, tn_sub, td_sub;
   logic signed [PW:0]      num_s;
   logic signed [EW-1:0]    num_ext;
   logic        [EW-1:0]    den_ext;

   // multiplier operand selection
   assign ad_s  = $signed({1'b0, ad_ff});
   assign bd_s  = $signed({1'b0, bd_ff});
   assign mb0_s = (op_ff == rau_pkg::OP_MUL) ? bn_ff : bd_s;

   // unsigned views and gcd differences
   assign n_u     = n_ff;
   assign d_u     = d_ff;
   assign xy_diff = x_ff - y_ff;
   assign yx_diff = y_ff - x_ff;

   // trial subtraction for both quotients
   assign g_ext  = {1'b0, g_ff};
   assign tn     = {rn_ff, qn_ff[PW-1]};
   assign td     = {rd_ff, qd_ff[PW-1]};
   assign tn_sub = tn - g_ext;
   assign td_sub = td - g_ext;

   // status to controller
   assign st.d_zero   = (d_ff == '0);
   assign st.gcd_done = (x_ff == '0) || (y_ff == '0);
   assign st.div_last = (cnt_ff == CW'(PW - 1));

   // next values
   always_comb begin
      op_in  = op_ff;
      an_in  = an_ff;
      ad_in  = ad_ff;
      bn_in  = bn_ff;
      bd_in  = bd_ff;
      m0_in  = m0_ff;
      m1_in  = m1_ff;
      m2_in  = m2_ff;
      n_in   = n_ff;
      d_in   = d_ff;
      nm_in  = nm_ff;
      dm_in  = dm_ff;
      neg_in = neg_ff;
      dz_in  = dz_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      g_in   = g_ff;
      qn_in  = qn_ff;
      qd_in  = qd_ff;
      rn_in  = rn_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;

      // operand capture
      if (cmd.load) begin
         op_in = req_type;
         an_in = a_num;
         ad_in = a_den;
         bn_in = b_num;
         bd_in = b_den;
      end

      // cross products
      if (cmd.mul) begin
         m0_in = PW'(an_ff) * PW'(mb0_s);
         m1_in = PW'(ad_s) * PW'(bn_ff);
         m2_in = PW'(ad_s) * PW'(bd_s);
      end

      // signed numerator and denominator
      if (cmd.sum) begin
         case (op_ff)
            rau_pkg::OP_ADD: n_in = m0_ff + m1_ff;
            rau_pkg::OP_SUB: n_in = m0_ff - m1_ff;
            default:         n_in = m0_ff;
         endcase
         d_in = (op_ff == rau_pkg::OP_DIV) ? m1_ff : m2_ff;
      end

      // sign and magnitudes
      if (cmd.abs) begin
         nm_in  = n_ff[PW-1] ? (~n_u + 1'b1) : n_u;
         dm_in  = d_ff[PW-1] ? (~d_u + 1'b1) : d_u;
         neg_in = n_ff[PW-1] ^ d_ff[PW-1];
         dz_in  = (d_ff == '0);
         x_in   = nm_in;
         y_in   = dm_in;
      end

      // binary gcd step; common factors of two come off the originals too
      if (cmd.gcd) begin
         if (!x_ff[0] && !y_ff[0]) begin
            x_in  = x_ff >> 1;
            y_in  = y_ff >> 1;
            nm_in = nm_ff >> 1;
            dm_in = dm_ff >> 1;
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (x_ff >= y_ff) begin
            x_in = xy_diff >> 1;
         end else begin
            y_in = yx_diff >> 1;
         end
      end

      // division setup
      if (cmd.div_init) begin
         g_in   = x_ff | y_ff;
         qn_in  = nm_ff;
         qd_in  = dm_ff;
         rn_in  = '0;
         rd_in  = '0;
         cnt_in = '0;
      end

      // one restoring step for both quotients
      if (cmd.div_step) begin
         if (tn >= g_ext) begin
            rn_in = tn_sub[PW-1:0];
            qn_in = {qn_ff[PW-2:0], 1'b1};
         end else begin
            rn_in = tn[PW-1:0];
            qn_in = {qn_ff[PW-2:0], 1'b0};
         end
         if (td >= g_ext) begin
            rd_in = td_sub[PW-1:0];
            qd_in = {qd_ff[PW-2:0], 1'b1};
         end else begin
            rd_in = td[PW-1:0];
            qd_in = {qd_ff[PW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      an_ff  <= an_in;
      ad_ff  <= ad_in;
      bn_ff  <= bn_in;
      bd_ff  <= bd_in;
      m0_ff  <= m0_in;
      m1_ff  <= m1_in;
      m2_ff  <= m2_in;
      n_ff   <= n_in;
      d_ff   <= d_in;
      nm_ff  <= nm_in;
      dm_ff  <= dm_in;
      neg_ff <= neg_in;
      dz_ff  <= dz_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      g_ff   <= g_in;
      qn_ff  <= qn_in;
      qd_ff  <= qd_in;
      rn_ff  <= rn_in;
      rd_ff  <= rd_in;
      cnt_ff <= cnt_in;
   end

   // signed result, wrapped to the output widths
   assign num_s   = neg_ff ? -$signed({1'b0, qn_ff}) : $signed({1'b0, qn_ff});
   assign num_ext = EW'(num_s);
   assign den_ext = EW'(qd_ff);

   assign res_num  = dz_ff ? '0 : num_ext[rau_pkg::RES_NUM_W-1:0];
   assign res_den  = dz_ff ? rau_pkg::RES_DEN_W'(1) : den_ext[rau_pkg::RES_DEN_W-1:0];
   assign div_zero = dz_ff;

   // after the first non-common step one gcd operand always stays odd
   a_gcd_odd: assert property (@(posedge clock)
      cmd.gcd |-> (x_ff[0] || y_ff[0] || (x_ff == nm_ff && y_ff == dm_ff)))
      else $error("rau_dp: both gcd operands even after reduction started");

   // divisor is never zero during division
   a_div_nonzero: assert property (@(posedge clock)
      cmd.div_step |-> (g_ff != '0))
      else $error("rau_dp: division by zero gcd");

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// checks the rational arithmetic unit against a predictor that works each
// reduced fraction out in 64-bit integers: directed corner cases first, then
// bursts of random operand mixes with receiver stalls, a long output
// hold-off and a full drain pause
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OPW          = 16;
   localparam int REQ_DATA_W   = ((4*OPW-2+7)/8)*8;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 150;
   localparam int RSP_HOLD     = 400;

   // one reduced fraction as the block reports it
   typedef struct packed {
      logic [rau_pkg::RES_NUM_W-1:0] num;
      logic [rau_pkg::RES_DEN_W-1:0] den;
      logic                          div_zero;
   } fraction_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [REQ_DATA_W-1:0]          req_tdata  = '0;
   logic [1:0]                     req_tuser  = rau_pkg::OP_ADD;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [rau_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;

   fraction_type expected_fractions[$];
   int           mismatch_count = 0;
   int           cycle_count    = 0;
   int           hold_requests  = 0;
   int           hold_served    = 0;
   int           hold_left      = 0;
   logic [11:0]  rx_cycle       = '0;

   rational_arith_unit #(
      .OPERAND_WIDTH(OPW)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // cross-multiply, move the sign up and cancel the common divisor
   function automatic fraction_type reduced_fraction(input rau_pkg::op_type op,
         input logic [OPW-1:0] a_n, input logic [OPW-2:0] a_d,
         input logic [OPW-1:0] b_n, input logic [OPW-2:0] b_d);
      longint          an, ad, bn, bd, n, d;
      longint unsigned mag_n, mag_d, x, y, t;
      logic            neg;
      fraction_type    f;
      an = $signed(a_n);
      bn = $signed(b_n);
      ad = a_d;
      bd = b_d;
      case (op)
         rau_pkg::OP_ADD: begin
            n = an * bd + ad * bn;
            d = ad * bd;
         end
         rau_pkg::OP_SUB: begin
            n = an * bd - ad * bn;
            d = ad * bd;
         end
         rau_pkg::OP_MUL: begin
            n = an * bn;
            d = ad * bd;
         end
         default: begin
            n = an * bd;
            d = ad * bn;
         end
      endcase
      // undefined quotient reads back as 0/1 with the flag
      if (d == 0) begin
         f.num      = '0;
         f.den      = rau_pkg::RES_DEN_W'(1);
         f.div_zero = 1'b1;
         return f;
      end
      neg   = (n < 0) != (d < 0);
      mag_n = (n < 0) ? -n : n;
      mag_d = (d < 0) ? -d : d;
      x = mag_n;
      y = mag_d;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      mag_n = mag_n / x;
      mag_d = mag_d / x;
      if (neg && mag_n != 0)
         mag_n = -mag_n;
      f.num      = mag_n[rau_pkg::RES_NUM_W-1:0];
      f.den      = mag_d[rau_pkg::RES_DEN_W-1:0];
      f.div_zero = 1'b0;
      return f;
   endfunction

   // numerator mix: full range, small, extremes, scaled small values
   function automatic logic [OPW-1:0] pick_numerator();
      int unsigned sel;
      int          v;
      sel = $urandom_range(0, 99);
      if (sel < 40)
         v = $urandom;
      else if (sel < 65)
         v = int'($urandom_range(0, 32)) - 16;
      else if (sel < 80)
         v = (int'($urandom_range(1, 15)) - 8) <<< $urandom_range(0, 11);
      else begin
         case ($urandom_range(0, 4))
            0:       v = -32768;
            1:       v = 32767;
            2:       v = -1;
            3:       v = 0;
            default: v = 1;
         endcase
      end
      return v[OPW-1:0];
   endfunction

   // denominator mix, with an out-of-range zero now and then
   function automatic logic [OPW-2:0] pick_denominator();
      int unsigned sel;
      int          v;
      sel = $urandom_range(0, 99);
      if (sel < 40)
         v = $urandom_range(1, 32767);
      else if (sel < 65)
         v = $urandom_range(1, 16);
      else if (sel < 80)
         v = $urandom_range(1, 15) << $urandom_range(0, 11);
      else if (sel < 88)
         v = 1 << $urandom_range(0, 14);
      else if (sel < 98) begin
         case ($urandom_range(0, 2))
            0:       v = 1;
            1:       v = 32767;
            default: v = 16384;
         endcase
      end else
         v = 0;
      return v[OPW-2:0];
   endfunction

   // offer one transaction and wait for it to be taken
   task automatic send_request(input rau_pkg::op_type op, input int an, input int ad,
         input int bn, input int bd);
      logic [OPW-1:0] a_n, b_n;
      logic [OPW-2:0] a_d, b_d;
      a_n = an[OPW-1:0];
      a_d = ad[OPW-2:0];
      b_n = bn[OPW-1:0];
      b_d = bd[OPW-2:0];
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'({b_d, b_n, a_d, a_n});
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      expected_fractions.push_back(reduced_fraction(op, a_n, a_d, b_n, b_d));
   endtask

   // sender gap, with junk on the data lines
   task automatic idle_cycles(input int n);
      req_tvalid <= 1'b0;
      req_tdata  <= REQ_DATA_W'({$urandom, $urandom});
      req_tuser  <= 2'($urandom_range(0, 3));
      repeat (n)
         @(posedge clock);
   endtask

   task automatic send_random_request();
      rau_pkg::op_type op;
      logic [OPW-1:0]  an, bn;
      logic [OPW-2:0]  ad, bd;
      op = rau_pkg::op_type'($urandom_range(0, 3));
      an = pick_numerator();
      ad = pick_denominator();
      bn = pick_numerator();
      bd = pick_denominator();
      if (op == rau_pkg::OP_DIV && $urandom_range(0, 19) == 0)
         bn = '0;
      send_request(op, an, ad, bn, bd);
   endtask

   task automatic report_mismatch(input string field, input longint want,
         input longint got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
   endtask

   // corner cases: extremes, sign handling, zero and divide by zero
   task automatic test_directed_cases();
      send_request(rau_pkg::OP_ADD, 1, 2, 1, 3);
      send_request(rau_pkg::OP_SUB, 1, 2, 1, 2);
      send_request(rau_pkg::OP_MUL, 6, 4, 2, 3);
      send_request(rau_pkg::OP_DIV, 3, 4, -3, 8);
      send_request(rau_pkg::OP_DIV, 5, 7, 0, 3);
      send_request(rau_pkg::OP_DIV, 0, 1, 0, 1);
      send_request(rau_pkg::OP_ADD, 1, 0, 1, 1);
      send_request(rau_pkg::OP_MUL, 2, 3, 4, 0);
      send_request(rau_pkg::OP_DIV, 1, 0, 1, 1);
      send_request(rau_pkg::OP_MUL, -32768, 1, -32768, 1);
      send_request(rau_pkg::OP_MUL, -32768, 1, 32767, 1);
      send_request(rau_pkg::OP_ADD, -32768, 32767, -32768, 32767);
      send_request(rau_pkg::OP_SUB, -32768, 32767, 32767, 32767);
      send_request(rau_pkg::OP_SUB, -32768, 32767, 32767, 1);
      send_request(rau_pkg::OP_DIV, 32767, 1, 1, 32767);
      send_request(rau_pkg::OP_DIV, 1, 32767, 32767, 1);
      send_request(rau_pkg::OP_MUL, 1, 32767, 1, 32767);
      send_request(rau_pkg::OP_ADD, 0, 5, 0, 7);
      send_request(rau_pkg::OP_DIV, -1, 1, -1, 1);
      send_request(rau_pkg::OP_MUL, 32767, 32767, -1, 1);
      send_request(rau_pkg::OP_DIV, 0, 5, -3, 1);
      send_request(rau_pkg::OP_SUB, 0, 1, 7, 2);
      send_request(rau_pkg::OP_ADD, 16384, 2, 16384, 2);
      send_request(rau_pkg::OP_DIV, -32768, 32767, -1, 32767);
      send_request(rau_pkg::OP_DIV, 1, 32767, -32768, 1);
   endtask

   // bursts of random items with random gaps, some back to back
   task automatic test_random_traffic(input int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 16);
         while (burst > 0 && sent < count) begin
            send_random_request();
            sent++;
            burst--;
         end
         if ($urandom_range(0, 9) >= 3)
            idle_cycles($urandom_range(1, 120));
      end
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_output_hold();
      hold_requests <= hold_requests + 1;
      repeat (15)
         send_random_request();
   endtask

   // sender waits for every result before going on
   task automatic test_drain_pause();
      repeat (10)
         send_random_request();
      idle_cycles(1);
      while (expected_fractions.size() != 0)
         @(posedge clock);
      idle_cycles($urandom_range(1, 40));
      repeat (10)
         send_random_request();
   endtask

   // receiver ready pattern: open, random, periodic and mostly stalled
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1'b1;
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= RSP_HOLD;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_cycle[11:10])
            2'd0:    rsp_tready <= 1'b1;
            2'd1:    rsp_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    rsp_tready <= (rx_cycle[2:0] >= 3'd3);
            default: rsp_tready <= ($urandom_range(0, 7) < 2);
         endcase
      end
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      fraction_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_fractions.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none actual %0d/%0d flag %0b",
                     $time, $signed(rsp_tdata[rau_pkg::RES_NUM_W-1:0]),
                     rsp_tdata[rau_pkg::RES_NUM_W +: rau_pkg::RES_DEN_W], rsp_tuser);
         end else begin
            want = expected_fractions.pop_front();
            if (rsp_tdata[rau_pkg::RES_NUM_W-1:0] !== want.num)
               report_mismatch("res_num", $signed(want.num),
                               $signed(rsp_tdata[rau_pkg::RES_NUM_W-1:0]));
            if (rsp_tdata[rau_pkg::RES_NUM_W +: rau_pkg::RES_DEN_W] !== want.den)
               report_mismatch("res_den", want.den,
                               rsp_tdata[rau_pkg::RES_NUM_W +: rau_pkg::RES_DEN_W]);
            if (rsp_tuser !== want.div_zero)
               report_mismatch("div_zero", want.div_zero, rsp_tuser);
         end
      end
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: FAIL");
      $finish;
   end

   // test sequence
   initial begin
      repeat (11)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_traffic(320);
      test_output_hold();
      test_drain_pause();
      test_random_traffic(320);
      idle_cycles(1);
      while (expected_fractions.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES)
         @(posedge clock);
      if (mismatch_count == 0 && expected_fractions.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/rau_pkg.sv
sv/rau_ctrl.sv
sv/rau_dp.sv
sv/rational_arith_unit.sv
tb/testbench.sv
